@@ sv/pcp_pkg.sv @@
// Package for the convex polygon hit test: widths, codes and shared types.
`timescale 1ns / 1ps
package pcp_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS   = 16;

  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int CFG_W  = 5;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int Z_W    = PROD_W + 1;

  localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = CFG_W'(4);
  localparam logic [CNT_W-1:0] MIN_VERTICES       = CNT_W'(3);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // per-cell control
  typedef struct packed {
    logic load;
    logic shift;
  } pcp_cell_ctrl_t;

  // sign of one edge test
  typedef struct packed {
    logic pos;
    logic neg;
  } pcp_side_t;

endpackage

@@ sv/pcp_cell.sv @@
// One vertex cell of the rotating ring: holds x and y, loads or takes its neighbour's.
`timescale 1ns / 1ps
module pcp_cell (
  input  logic                    clk,
  input  pcp_pkg::pcp_cell_ctrl_t ctrl,
  input  pcp_pkg::coord_t         load_x,
  input  pcp_pkg::coord_t         load_y,
  input  pcp_pkg::coord_t         nb_x,
  input  pcp_pkg::coord_t         nb_y,
  output pcp_pkg::coord_t         x,
  output pcp_pkg::coord_t         y
);

  pcp_pkg::coord_t x_r;
  pcp_pkg::coord_t y_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r <= load_x;
      y_r <= load_y;
    end else if (ctrl.shift) begin
      x_r <= nb_x;
      y_r <= nb_y;
    end
  end

  assign x = x_r;
  assign y = y_r;

endmodule

@@ sv/pcp_cross.sv @@
// Three-stage edge unit: sign of z of cross(b - a, p - a).
`timescale 1ns / 1ps
module pcp_cross (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 issue,
  input  pcp_pkg::coord_t      ax,
  input  pcp_pkg::coord_t      ay,
  input  pcp_pkg::coord_t      bx,
  input  pcp_pkg::coord_t      by,
  input  pcp_pkg::coord_t      px,
  input  pcp_pkg::coord_t      py,
  output logic                 busy,
  output logic                 res_valid,
  output pcp_pkg::pcp_side_t   res_side
);

  logic signed [pcp_pkg::DIFF_W-1:0] ex_r, ey_r, dx_r, dy_r;
  logic signed [pcp_pkg::PROD_W-1:0] p1_r, p2_r;
  logic signed [pcp_pkg::Z_W-1:0]    z;
  logic                              v1_r, v2_r, v3_r;
  pcp_pkg::pcp_side_t                side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign z = pcp_pkg::Z_W'(p1_r) - pcp_pkg::Z_W'(p2_r);

  always_ff @(posedge clk) begin
    ex_r <= pcp_pkg::DIFF_W'(bx) - pcp_pkg::DIFF_W'(ax);
    ey_r <= pcp_pkg::DIFF_W'(by) - pcp_pkg::DIFF_W'(ay);
    dx_r <= pcp_pkg::DIFF_W'(px) - pcp_pkg::DIFF_W'(ax);
    dy_r <= pcp_pkg::DIFF_W'(py) - pcp_pkg::DIFF_W'(ay);
    p1_r <= ex_r * dy_r;
    p2_r <= ey_r * dx_r;
    side_r.pos <= !z[pcp_pkg::Z_W-1] && (z != '0);
    side_r.neg <= z[pcp_pkg::Z_W-1];
  end

  assign busy      = v1_r || v2_r || v3_r;
  assign res_valid = v3_r;
  assign res_side  = side_r;

endmodule

@@ sv/point_in_convex_polygon.sv @@
// Top level of the convex polygon hit test: vertex cell ring, edge unit and control.
//
//  channel  ports                                         direction  payload
//  in       in_valid / in_stall                            in         command, vertex_index, x, y
//  out      out_valid / out_stall                          out        inside_res
//  cfg      cfg_wr_en / cfg_wr_data                        in         vertex_count
//
// A load is written into its vertex cell when accepted. A query with n vertices in use turns
// the ring through all n cells while the edge unit takes each edge, drains the edge unit, sees
// it idle in the drain state and then loads the result register. Below three vertices a query
// goes from idle straight to the finish state, which loads the result register. The next
// transaction is taken once the result is loaded. Input is stalled while a query runs and
// while its result waits on a full, stalled output register; a load may follow while a result
// waits. rst_n is synchronous; vertex slots are not cleared and hold nothing until loaded.
`timescale 1ns / 1ps
module point_in_convex_polygon (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_command,
  input  logic [pcp_pkg::IDX_W-1:0]        in_vertex_index,
  input  logic signed [pcp_pkg::COORD_BITS-1:0] in_coord_x,
  input  logic signed [pcp_pkg::COORD_BITS-1:0] in_coord_y,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_inside_res,
  input  logic                             cfg_wr_en,
  input  logic [pcp_pkg::CFG_W-1:0]        cfg_wr_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [pcp_pkg::CFG_W-1:0]   cfg_count_r;
  logic [pcp_pkg::CNT_W-1:0]   n_eff;
  logic [pcp_pkg::CNT_W-1:0]   n_r, n_nxt;
  logic [pcp_pkg::CNT_W-1:0]   k_r, k_nxt;
  logic                        any_pos_r, any_pos_nxt;
  logic                        any_neg_r, any_neg_nxt;
  logic                        any_zero_r, any_zero_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_inside_r, out_inside_nxt;
  pcp_pkg::coord_t             px_r, py_r;

  logic                        in_acc;
  logic                        issue;
  logic                        cross_busy;
  logic                        res_valid;
  pcp_pkg::pcp_side_t          res_side;

  pcp_pkg::coord_t             cell_x  [pcp_pkg::MAX_VERTICES];
  pcp_pkg::coord_t             cell_y  [pcp_pkg::MAX_VERTICES];
  pcp_pkg::coord_t             nb_x    [pcp_pkg::MAX_VERTICES];
  pcp_pkg::coord_t             nb_y    [pcp_pkg::MAX_VERTICES];
  pcp_pkg::pcp_cell_ctrl_t     cell_ctrl [pcp_pkg::MAX_VERTICES];

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign issue    = (state_r == ST_RUN);

  always_comb begin
    if (cfg_count_r > pcp_pkg::CFG_W'(pcp_pkg::MAX_VERTICES)) begin
      n_eff = pcp_pkg::CNT_W'(pcp_pkg::MAX_VERTICES);
    end else begin
      n_eff = pcp_pkg::CNT_W'(cfg_count_r);
    end
  end

  // ring of cells: cell j takes from cell j+1, the last cell in use wraps to cell 0
  for (genvar j = 0; j < pcp_pkg::MAX_VERTICES; j++) begin : g_cell
    localparam int NEXT = (j + 1) % pcp_pkg::MAX_VERTICES;

    assign nb_x[j] = (pcp_pkg::CNT_W'(j + 1) == n_r) ? cell_x[0] : cell_x[NEXT];
    assign nb_y[j] = (pcp_pkg::CNT_W'(j + 1) == n_r) ? cell_y[0] : cell_y[NEXT];
    assign cell_ctrl[j].load  = in_acc && (in_command == pcp_pkg::CMD_LOAD) &&
                                (in_vertex_index == pcp_pkg::IDX_W'(j));
    assign cell_ctrl[j].shift = issue && (pcp_pkg::CNT_W'(j) < n_r);

    pcp_cell u_cell (
      .clk    (clk),
      .ctrl   (cell_ctrl[j]),
      .load_x (in_coord_x),
      .load_y (in_coord_y),
      .nb_x   (nb_x[j]),
      .nb_y   (nb_y[j]),
      .x      (cell_x[j]),
      .y      (cell_y[j])
    );
  end

  pcp_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .ax        (cell_x[0]),
    .ay        (cell_y[0]),
    .bx        (cell_x[1]),
    .by        (cell_y[1]),
    .px        (px_r),
    .py        (py_r),
    .busy      (cross_busy),
    .res_valid (res_valid),
    .res_side  (res_side)
  );

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    any_pos_nxt    = any_pos_r;
    any_neg_nxt    = any_neg_r;
    any_zero_nxt   = any_zero_r;
    out_valid_nxt  = out_valid_r;
    out_inside_nxt = out_inside_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (res_valid) begin
      any_pos_nxt  = any_pos_r || res_side.pos;
      any_neg_nxt  = any_neg_r || res_side.neg;
      any_zero_nxt = any_zero_r || (!res_side.pos && !res_side.neg);
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_command == pcp_pkg::CMD_QUERY)) begin
          n_nxt        = n_eff;
          k_nxt        = '0;
          any_pos_nxt  = 1'b0;
          any_neg_nxt  = 1'b0;
          // fewer than three vertices is no polygon
          any_zero_nxt = (n_eff < pcp_pkg::MIN_VERTICES);
          state_nxt    = (n_eff < pcp_pkg::MIN_VERTICES) ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        k_nxt = k_r + pcp_pkg::CNT_W'(1);
        if (k_nxt == n_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!cross_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = !any_zero_r && !(any_pos_r && any_neg_r);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_count_r <= pcp_pkg::VERTEX_COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    k_r          <= k_nxt;
    any_pos_r    <= any_pos_nxt;
    any_neg_r    <= any_neg_nxt;
    any_zero_r   <= any_zero_nxt;
    out_inside_r <= out_inside_nxt;
    if (in_acc && (in_command == pcp_pkg::CMD_QUERY)) begin
      px_r <= in_coord_x;
      py_r <= in_coord_y;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

endmodule
